[design/sorted_id_route_table_assert.svh]
// assertion macros for the sorted id route table
`ifndef SORTED_ID_ROUTE_TABLE_ASSERT_SVH
`define SORTED_ID_ROUTE_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset as well
`define SRT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SRT_ASSERT(lbl, prop, msg)
`define SRT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[design/srt_pkg.sv]
`default_nettype none

package srt_pkg;

  localparam int NUM_IFACES = 4;
  localparam int LIST_DEPTH = 64;
  localparam int PDU_COUNT  = 256;

  localparam int NUM_LISTS = 2 * NUM_IFACES;
  localparam int LIST_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int IDX_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int ADDR_W    = LIST_W + IDX_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam int KEY_W  = 32;
  localparam int PDU_W  = 8;
  localparam int FILL_W = 7;
  localparam int STAT_W = 2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic             mode;
    logic             direction;
    logic [1:0]       interface_req;
    logic [KEY_W-1:0] key;
    logic [PDU_W-1:0] pdu_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PDU_W-1:0]  pdu_result;
    logic [FILL_W-1:0] list_fill;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PDU_W-1:0] pdu;
  } entry_t;

endpackage

`default_nettype wire

[design/sorted_id_route_table.sv]
`default_nettype none
// Sorted id route table: one sorted list of (message id, pdu index) pairs per
// direction and interface, held in a single entry memory with registered reads.
// Requests: start_i with req_i, taken at a clock edge where busy_o is low.
// Results: rsp_o is valid for exactly one cycle while done_o is high; the
// receiver cannot stall, so it must sample rsp_o in that cycle.
// A lookup issues its first memory read in the accept cycle and then does one
// binary search probe per cycle (compare, narrow, next read), at most about
// log2(LIST_DEPTH) + 1 probes. An insert moves one larger entry up per cycle
// (writing the value read from entry j-1 into slot j while reading entry j-2
// in the same cycle). Misrouted interfaces, full lists and empty-list
// lookups answer the cycle after accept. A new request may be taken in the
// done_o cycle.
// Reset clears the per-list fill counts; entry memory needs no clearing since
// only entries below a list's count are ever read.
`include "sorted_id_route_table_assert.svh"

module sorted_id_route_table
  import srt_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output rsp_t      rsp_o
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_LK      = 2'd1;
  localparam logic [1:0] S_INS_CMP = 2'd2;
  localparam logic [1:0] S_INS_PUT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;
  req_t             req_q, req_d;
  logic [LIST_W-1:0] list_q, list_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [IDX_W-1:0] mid_q, mid_d;
  logic [CNT_W-1:0] j_q, j_d;

  logic [CNT_W-1:0] counts_q [NUM_LISTS];
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wval;

  entry_t           mem_q [MEM_DEPTH];
  entry_t           rd_q;
  logic [ADDR_W-1:0] raddr;
  logic             mem_we;
  logic [ADDR_W-1:0] waddr;
  entry_t           wdata;

  logic             accept;
  logic             bad_iface;
  logic [LIST_W-1:0] list_sel;
  logic [CNT_W-1:0] cnt_sel;
  logic [IDX_W-1:0] mid_first;

  logic             key_lt, key_gt;
  logic [CNT_W-1:0] lo_nxt, hi_nxt;
  logic [SUM_W-1:0] msum;
  logic [IDX_W-1:0] mid_nxt;
  logic [CNT_W-1:0] jm1, jm2, cnt_inc;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign accept = start_i && !busy_o;

  assign bad_iface = (int'(req_i.interface_req) >= NUM_IFACES);
  assign list_sel  = LIST_W'(int'(req_i.direction) * NUM_IFACES + int'(req_i.interface_req));
  assign cnt_sel   = bad_iface ? '0 : counts_q[list_sel];
  assign mid_first = IDX_W'((cnt_sel - CNT_W'(1)) >> 1);

  // binary search step on the entry read back this cycle
  assign key_lt  = (req_q.key < rd_q.key);
  assign key_gt  = (req_q.key > rd_q.key);
  assign lo_nxt  = key_gt ? (CNT_W'(mid_q) + CNT_W'(1)) : lo_q;
  assign hi_nxt  = key_lt ? CNT_W'(mid_q) : hi_q;
  assign msum    = SUM_W'(lo_nxt) + SUM_W'(hi_nxt) - SUM_W'(1);
  assign mid_nxt = IDX_W'(msum >> 1);

  assign jm1     = j_q - CNT_W'(1);
  assign jm2     = j_q - CNT_W'(2);
  assign cnt_inc = cnt_q + CNT_W'(1);

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    req_d    = req_q;
    list_d   = list_q;
    cnt_d    = cnt_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    j_d      = j_q;
    raddr    = '0;
    mem_we   = 1'b0;
    waddr    = '0;
    wdata    = '0;
    cnt_we   = 1'b0;
    cnt_wval = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d  = req_i;
          list_d = list_sel;
          cnt_d  = cnt_sel;
          if (bad_iface) begin
            done_d            = 1'b1;
            rsp_d.status      = (req_i.mode == MODE_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
            rsp_d.pdu_result  = '0;
            rsp_d.list_fill   = '0;
          end else if (req_i.mode == MODE_INSERT) begin
            j_d = cnt_sel;
            if (int'(cnt_sel) >= LIST_DEPTH) begin
              done_d           = 1'b1;
              rsp_d.status     = ST_FULL;
              rsp_d.pdu_result = '0;
              rsp_d.list_fill  = FILL_W'(cnt_sel);
            end else if (cnt_sel == '0) begin
              state_d = S_INS_PUT;
            end else begin
              raddr   = {list_sel, IDX_W'(cnt_sel - CNT_W'(1))};
              state_d = S_INS_CMP;
            end
          end else begin
            if (cnt_sel == '0) begin
              done_d           = 1'b1;
              rsp_d.status     = ST_NOT_FOUND;
              rsp_d.pdu_result = '0;
              rsp_d.list_fill  = '0;
            end else begin
              lo_d    = '0;
              hi_d    = cnt_sel;
              mid_d   = mid_first;
              raddr   = {list_sel, mid_first};
              state_d = S_LK;
            end
          end
        end
      end

      S_LK: begin
        if (!key_lt && !key_gt) begin
          done_d           = 1'b1;
          rsp_d.status     = ST_OK;
          rsp_d.pdu_result = rd_q.pdu;
          rsp_d.list_fill  = FILL_W'(cnt_q);
          state_d          = S_IDLE;
        end else begin
          lo_d = lo_nxt;
          hi_d = hi_nxt;
          if (lo_nxt < hi_nxt) begin
            mid_d = mid_nxt;
            raddr = {list_q, mid_nxt};
          end else begin
            done_d           = 1'b1;
            rsp_d.status     = ST_NOT_FOUND;
            rsp_d.pdu_result = '0;
            rsp_d.list_fill  = FILL_W'(cnt_q);
            state_d          = S_IDLE;
          end
        end
      end

      S_INS_CMP: begin
        if (key_lt) begin
          // shift the larger entry up one slot, read the next one down
          mem_we = 1'b1;
          waddr  = {list_q, IDX_W'(j_q)};
          wdata  = rd_q;
          j_d    = jm1;
          if (jm1 == '0) begin
            state_d = S_INS_PUT;
          end else begin
            raddr = {list_q, IDX_W'(jm2)};
          end
        end else begin
          mem_we           = 1'b1;
          waddr            = {list_q, IDX_W'(j_q)};
          wdata.key        = req_q.key;
          wdata.pdu        = req_q.pdu_value;
          cnt_we           = 1'b1;
          cnt_wval         = cnt_inc;
          done_d           = 1'b1;
          rsp_d.status     = ST_OK;
          rsp_d.pdu_result = '0;
          rsp_d.list_fill  = FILL_W'(cnt_inc);
          state_d          = S_IDLE;
        end
      end

      S_INS_PUT: begin
        mem_we           = 1'b1;
        waddr            = {list_q, IDX_W'(j_q)};
        wdata.key        = req_q.key;
        wdata.pdu        = req_q.pdu_value;
        cnt_we           = 1'b1;
        cnt_wval         = cnt_inc;
        done_d           = 1'b1;
        rsp_d.status     = ST_OK;
        rsp_d.pdu_result = '0;
        rsp_d.list_fill  = FILL_W'(cnt_inc);
        state_d          = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cnt_we) begin
        counts_q[list_q] <= cnt_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q  <= rsp_d;
    req_q  <= req_d;
    list_q <= list_d;
    cnt_q  <= cnt_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    j_q    <= j_d;
  end

  // during a shift, read and write never hit the same entry in one cycle: it
  // writes slot j while reading slot j-2
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  `SRT_ASSERT_RST(a_reset_quiet, !rst_ni |-> !done_o && !busy_o, "outputs active in reset")
  `SRT_ASSERT(a_done_idle, done_q |-> state_q == S_IDLE, "result strobe while still busy")
  `SRT_ASSERT(a_search_bounds, state_q == S_LK |-> lo_q < hi_q, "search probe on empty range")
  `SRT_ASSERT(a_shift_slot, state_q == S_INS_CMP |-> j_q != '0, "insert compare below slot 0")
  `SRT_ASSERT(a_fill_limit, done_q |-> int'(rsp_q.list_fill) <= LIST_DEPTH, "fill beyond depth")

endmodule

`default_nettype wire
